FILE: sv/aass_pkg.sv
// Shared types, constants and helper functions for the averaging seven-segment scanner.
package aass_pkg;

   localparam int unsigned SWITCH_W    = 3;
   localparam int unsigned SAMPLE_W    = 10;
   localparam int unsigned AVG_W       = 10;
   localparam int unsigned SEG_W       = 8;
   localparam int unsigned DIGIT_COUNT = 4;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned POS_W       = 2;
   localparam int unsigned POINT_BIT   = 7;

   localparam logic [SWITCH_W-1:0] MODE_TEST            = 3'd1;
   localparam logic [SWITCH_W-1:0] MODE_POINT_HUNDREDS  = 3'd2;
   localparam logic [SWITCH_W-1:0] MODE_POINT_THOUSANDS = 3'd4;

   localparam logic [POS_W-1:0] POS_HUNDREDS  = 2'd2;
   localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd3;

   localparam logic [SEG_W-1:0]       SEG_BLANK   = 8'hFF;
   localparam logic [DIGIT_COUNT-1:0] ENABLES_OFF = 4'hF;

   localparam logic [SEG_W-1:0] SEG_FONT [16] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hD8,
      8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
   };

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type [DIGIT_COUNT-1:0] digits_type;

   // Item handed from the averaging stage to the display stage.
   typedef struct packed {
      logic [SWITCH_W-1:0] switches;
      logic                avg_new;
      logic [AVG_W-1:0]    avg;
   } mid_type;

   function automatic logic [SEG_W-1:0] seg_pattern(input digit_type digit,
                                                    input logic point_lit);
      logic [SEG_W-1:0] pat;
      pat            = SEG_FONT[digit];
      pat[POINT_BIT] = ~point_lit;
      return pat;
   endfunction

   // Splits an average below 1024 into decimal digits, ones first.
   // Divisions by 100 and 10 use reciprocal multiplies that are exact in this range.
   function automatic digits_type split_digits(input logic [AVG_W-1:0] avg);
      logic [AVG_W-1:0] rem1;
      logic [15:0]      prod_h;
      digit_type        hund;
      logic [6:0]       rem2;
      logic [14:0]      prod_t;
      digit_type        tens;
      digits_type       d;
      d[3]   = (avg >= 10'd1000) ? 4'd1 : 4'd0;
      rem1   = (avg >= 10'd1000) ? avg - 10'd1000 : avg;
      prod_h = 16'(rem1) * 16'd41;
      hund   = prod_h[15:12];
      rem2   = 7'(rem1 - 10'(hund) * 10'd100);
      prod_t = 15'(rem2) * 15'd205;
      tens   = prod_t[14:11];
      d[2]   = hund;
      d[1]   = tens;
      d[0]   = 4'(rem2 - 7'(tens) * 7'd10);
      return d;
   endfunction

endpackage

FILE: sv/aass_accum.sv
// Sample accumulator and constant divider stage that produces each new average.
module aass_accum #(
   parameter int unsigned AVERAGE_SAMPLES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [aass_pkg::SWITCH_W-1:0] switches,
   input  logic [aass_pkg::SAMPLE_W-1:0] sample,
   output aass_pkg::mid_type             mid
);

   localparam int unsigned COUNT_W   = $clog2(AVERAGE_SAMPLES);
   localparam int unsigned TOTAL_W   =
      $clog2(AVERAGE_SAMPLES * ((1 << aass_pkg::SAMPLE_W) - 1) + 1);
   localparam int unsigned DIV_SHIFT = TOTAL_W + COUNT_W;
   localparam int unsigned RECIP     =
      ((1 << DIV_SHIFT) + AVERAGE_SAMPLES - 1) / AVERAGE_SAMPLES;
   localparam int unsigned PROD_W    = TOTAL_W + DIV_SHIFT;

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0]   sum_ff, sum_in;
   logic [TOTAL_W-1:0]   total;
   logic [COUNT_W:0]     count_next;
   logic                 full;
   logic [DIV_SHIFT-1:0] recip_v;
   logic [PROD_W-1:0]    prod;
   aass_pkg::mid_type    mid_ff, mid_in;

   assign recip_v = DIV_SHIFT'(RECIP);

   always_comb begin
      total      = sum_ff + TOTAL_W'(sample);
      count_next = (COUNT_W + 1)'(count_ff) + 1'b1;
      full       = count_next >= (COUNT_W + 1)'(AVERAGE_SAMPLES);
      // The rounding error of the reciprocal stays below one step over the whole sum range.
      prod       = PROD_W'(total) * PROD_W'(recip_v);
      sum_in     = full ? '0 : total;
      count_in   = full ? '0 : count_next[COUNT_W-1:0];
      mid_in.switches = switches;
      mid_in.avg_new  = full;
      mid_in.avg      = prod[DIV_SHIFT +: aass_pkg::AVG_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (advance) begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_ff <= mid_in;
      end
   end

   assign mid = mid_ff;

endmodule

FILE: sv/aass_display.sv
// Digit store, scan position and segment decoding stage of the display.
module aass_display (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  aass_pkg::mid_type                mid,
   output logic [aass_pkg::SEG_W-1:0]       segments,
   output logic [aass_pkg::DIGIT_COUNT-1:0] digit_enables,
   output logic                             led_mode_two,
   output logic                             led_mode_four
);

   aass_pkg::digits_type                digits_ff, digits_in;
   logic [aass_pkg::POS_W-1:0]          scan_ff, scan_in;
   logic [aass_pkg::SEG_W-1:0]          segments_ff, segments_in;
   logic [aass_pkg::DIGIT_COUNT-1:0]    enables_ff, enables_in;
   logic                                led_two_ff, led_two_in;
   logic                                led_four_ff, led_four_in;
   aass_pkg::digit_type                 cur_digit;

   always_comb begin
      // A freshly finished average is shown in the same item.
      digits_in   = mid.avg_new ? aass_pkg::split_digits(mid.avg) : digits_ff;
      cur_digit   = digits_in[scan_ff];
      enables_in  = ~(aass_pkg::DIGIT_COUNT'(1) << scan_ff);
      scan_in     = scan_ff + 1'b1;
      led_two_in  = mid.switches == aass_pkg::MODE_POINT_HUNDREDS;
      led_four_in = mid.switches == aass_pkg::MODE_POINT_THOUSANDS;
      unique case (mid.switches)
         aass_pkg::MODE_TEST: begin
            segments_in = aass_pkg::seg_pattern(aass_pkg::DIGIT_W'(scan_ff), 1'b1);
         end
         aass_pkg::MODE_POINT_HUNDREDS: begin
            segments_in = aass_pkg::seg_pattern(cur_digit,
                                                scan_ff == aass_pkg::POS_HUNDREDS);
         end
         aass_pkg::MODE_POINT_THOUSANDS: begin
            segments_in = aass_pkg::seg_pattern(cur_digit,
                                                scan_ff == aass_pkg::POS_THOUSANDS);
         end
         default: begin
            segments_in = aass_pkg::SEG_BLANK;
            enables_in  = aass_pkg::ENABLES_OFF;
            scan_in     = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= '0;
         scan_ff   <= '0;
      end else if (advance) begin
         digits_ff <= digits_in;
         scan_ff   <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         segments_ff <= segments_in;
         enables_ff  <= enables_in;
         led_two_ff  <= led_two_in;
         led_four_ff <= led_four_in;
      end
   end

   assign segments      = segments_ff;
   assign digit_enables = enables_ff;
   assign led_mode_two  = led_two_ff;
   assign led_mode_four = led_four_ff;

endmodule

FILE: sv/adc_average_sevenseg_scan.sv
// Top level of the averaging converter readout on a scanned four-digit display.
//
// Each item on the req_ channel is one scan step: a 3-bit switch word and one
// 10-bit converter sample. Each accepted item yields exactly one item on the
// rsp_ channel: the active-low segment pattern and digit enables for at most one digit
// of a common-anode display, plus the two mode LEDs.
// Samples are summed in blocks of AVERAGE_SAMPLES; the last sample of a block
// completes the average, which is shown from that same item on.
// The pipeline has three register stages: input register, accumulator and
// divider, then digit split and segment decode. One item is taken every cycle
// while rsp_stall is low, a rate set by the accumulator's sum and count
// registers feeding back on themselves.
// When the receiver raises rsp_stall, the result holds and the stages behind it
// keep filling until each is occupied; only then is req_stall raised.
// Synchronous reset empties the pipeline, clears the running sum and count,
// sets all shown digits to zero and returns the scan to the ones digit.
module adc_average_sevenseg_scan #(
   parameter int unsigned AVERAGE_SAMPLES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [aass_pkg::SWITCH_W-1:0]    req_switches,
   input  logic [aass_pkg::SAMPLE_W-1:0]    req_adc_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [aass_pkg::SEG_W-1:0]       rsp_segments,
   output logic [aass_pkg::DIGIT_COUNT-1:0] rsp_digit_enables,
   output logic                             rsp_led_mode_two,
   output logic                             rsp_led_mode_four
);

   logic                          in_valid_ff, mid_valid_ff, rsp_valid_ff;
   logic [aass_pkg::SWITCH_W-1:0] in_switches_ff;
   logic [aass_pkg::SAMPLE_W-1:0] in_sample_ff;
   logic                          in_load, mid_load, out_load;
   aass_pkg::mid_type             mid;

   always_comb begin
      out_load  = mid_valid_ff && (!rsp_valid_ff || !rsp_stall);
      mid_load  = in_valid_ff && (!mid_valid_ff || out_load);
      req_stall = in_valid_ff && !mid_load;
      in_load   = req_valid && !req_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_load || mid_load) begin
            in_valid_ff <= in_load;
         end
         if (mid_load || out_load) begin
            mid_valid_ff <= mid_load;
         end
         if (out_load || !rsp_stall) begin
            rsp_valid_ff <= out_load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_switches_ff <= req_switches;
         in_sample_ff   <= req_adc_sample;
      end
   end

   aass_accum #(
      .AVERAGE_SAMPLES(AVERAGE_SAMPLES)
   ) u_accum (
      .clock   (clock),
      .reset   (reset),
      .advance (mid_load),
      .switches(in_switches_ff),
      .sample  (in_sample_ff),
      .mid     (mid)
   );

   aass_display u_display (
      .clock        (clock),
      .reset        (reset),
      .advance      (out_load),
      .mid          (mid),
      .segments     (rsp_segments),
      .digit_enables(rsp_digit_enables),
      .led_mode_two (rsp_led_mode_two),
      .led_mode_four(rsp_led_mode_four)
   );

   assign rsp_valid = rsp_valid_ff;

   // At most one digit is ever driven.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(~rsp_digit_enables) <= 1)
      else $error("more than one digit enabled");

   // A dark display must carry no lit segment.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_digit_enables == aass_pkg::ENABLES_OFF)
         |-> rsp_segments == aass_pkg::SEG_BLANK)
      else $error("segments lit while all digits are off");

   // The input side only stalls while its register holds an item.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");

   // The two mode LEDs never light together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_led_mode_two && rsp_led_mode_four))
      else $error("both mode LEDs lit");

endmodule

FILE: tb/display_scan_checker.sv
// Checker that predicts each display step of the averaging scanner and compares it.
`timescale 1ns / 1ps

module display_scan_checker #(
   parameter int unsigned AVERAGE_SAMPLES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [aass_pkg::SWITCH_W-1:0]    req_switches,
   input  logic [aass_pkg::SAMPLE_W-1:0]    req_adc_sample,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [aass_pkg::SEG_W-1:0]       rsp_segments,
   input  logic [aass_pkg::DIGIT_COUNT-1:0] rsp_digit_enables,
   input  logic                             rsp_led_mode_two,
   input  logic                             rsp_led_mode_four,
   output int                               mismatch_count,
   output int                               pending_count,
   output int                               averages_done
);

   typedef struct packed {
      logic [aass_pkg::SEG_W-1:0]       segments;
      logic [aass_pkg::DIGIT_COUNT-1:0] enables;
      logic                             led_two;
      logic                             led_four;
   } display_step_type;

   display_step_type expected_steps[$];

   logic [5:0]                 block_count;
   logic [15:0]                block_sum;
   aass_pkg::digit_type        shown_digits [aass_pkg::DIGIT_COUNT];
   logic [aass_pkg::POS_W-1:0] scan_pos;
   int                         steps_checked;

   function automatic logic [aass_pkg::SEG_W-1:0] glyph(input aass_pkg::digit_type digit,
                                                       input logic point_lit);
      logic [aass_pkg::SEG_W-1:0] pat;
      pat = aass_pkg::SEG_FONT[digit] | 8'h80;
      if (point_lit)
         pat[aass_pkg::POINT_BIT] = 1'b0;
      return pat;
   endfunction

   task automatic predict_step(input logic [aass_pkg::SWITCH_W-1:0] sw,
                               input logic [aass_pkg::SAMPLE_W-1:0] smp);
      int unsigned                total;
      int unsigned                avg;
      logic [aass_pkg::POS_W-1:0] pos;
      logic                       lit;
      display_step_type           step;
      total = int'(block_sum) + int'(smp);
      if (int'(block_count) + 1 >= AVERAGE_SAMPLES) begin
         avg = total / AVERAGE_SAMPLES;
         shown_digits[0] = aass_pkg::digit_type'(avg % 10);
         shown_digits[1] = aass_pkg::digit_type'((avg / 10) % 10);
         shown_digits[2] = aass_pkg::digit_type'((avg / 100) % 10);
         shown_digits[3] = aass_pkg::digit_type'((avg / 1000) % 10);
         block_sum   = '0;
         block_count = '0;
         averages_done++;
      end else begin
         block_sum   = 16'(total);
         block_count = block_count + 6'd1;
      end
      pos           = scan_pos;
      lit           = 1'b1;
      step.segments = aass_pkg::SEG_BLANK;
      step.enables  = aass_pkg::ENABLES_OFF;
      case (sw)
         aass_pkg::MODE_TEST:
            step.segments = glyph(aass_pkg::digit_type'(pos), 1'b1);
         aass_pkg::MODE_POINT_HUNDREDS:
            step.segments = glyph(shown_digits[pos], pos == aass_pkg::POS_HUNDREDS);
         aass_pkg::MODE_POINT_THOUSANDS:
            step.segments = glyph(shown_digits[pos], pos == aass_pkg::POS_THOUSANDS);
         default:
            lit = 1'b0;
      endcase
      if (lit) begin
         step.enables = aass_pkg::ENABLES_OFF & ~(4'b0001 << pos);
         scan_pos     = pos + 2'd1;
      end else begin
         scan_pos = '0;
      end
      step.led_two  = (sw == aass_pkg::MODE_POINT_HUNDREDS);
      step.led_four = (sw == aass_pkg::MODE_POINT_THOUSANDS);
      expected_steps.push_back(step);
   endtask

   task automatic compare_step();
      display_step_type want;
      display_step_type got;
      got = '{rsp_segments, rsp_digit_enables, rsp_led_mode_two, rsp_led_mode_four};
      steps_checked++;
      if (expected_steps.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Result %0d arrived with nothing expected: seg=%02h en=%h led2=%b led4=%b",
                     steps_checked, got.segments, got.enables, got.led_two, got.led_four);
      end else begin
         want = expected_steps.pop_front();
         if (got.segments !== want.segments || got.enables !== want.enables ||
             got.led_two !== want.led_two || got.led_four !== want.led_four) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display({"Result %0d mismatch: expected seg=%02h en=%h led2=%b led4=%b,",
                         " got seg=%02h en=%h led2=%b led4=%b"},
                        steps_checked, want.segments, want.enables, want.led_two,
                        want.led_four, got.segments, got.enables, got.led_two,
                        got.led_four);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         block_count    = '0;
         block_sum      = '0;
         scan_pos       = '0;
         mismatch_count = 0;
         averages_done  = 0;
         steps_checked  = 0;
         for (int d = 0; d < aass_pkg::DIGIT_COUNT; d++)
            shown_digits[d] = '0;
         expected_steps.delete();
      end else begin
         // Predict first so that a result leaving in the same cycle still finds its item.
         if (req_valid && !req_stall)
            predict_step(req_switches, req_adc_sample);
         if (rsp_valid && !rsp_stall)
            compare_step();
      end
      pending_count = expected_steps.size();
   end

endmodule

FILE: tb/testbench.sv
// Top of the testbench: clock, reset, item stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned AVERAGE_SAMPLES = 64;
   localparam int unsigned PHASE_ITEMS     = 520;
   localparam int unsigned PRESSURE_ITEMS  = 60;
   localparam int unsigned HOLD_CYCLES     = 80;
   localparam int unsigned IDLE_LIMIT      = 5000;

   localparam logic [aass_pkg::SWITCH_W-1:0] SW_ALL_OFF        = 3'd0;
   localparam logic [aass_pkg::SWITCH_W-1:0] SW_TEST_HUNDREDS  = 3'd3;
   localparam logic [aass_pkg::SWITCH_W-1:0] SW_TEST_THOUSANDS = 3'd5;
   localparam logic [aass_pkg::SWITCH_W-1:0] SW_BOTH_POINTS    = 3'd6;
   localparam logic [aass_pkg::SWITCH_W-1:0] SW_ALL_ON         = 3'd7;
   localparam logic [aass_pkg::SAMPLE_W-1:0] SAMPLE_MAX        = '1;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [aass_pkg::SWITCH_W-1:0]    req_switches;
   logic [aass_pkg::SAMPLE_W-1:0]    req_adc_sample;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [aass_pkg::SEG_W-1:0]       rsp_segments;
   logic [aass_pkg::DIGIT_COUNT-1:0] rsp_digit_enables;
   logic                             rsp_led_mode_two;
   logic                             rsp_led_mode_four;

   int   mismatch_count;
   int   pending_count;
   int   averages_done;
   int   send_idle_pct;
   int   recv_idle_pct;
   logic hold_request;
   logic hold_taken;
   int   items_sent;
   int   idle_cycles;

   adc_average_sevenseg_scan #(
      .AVERAGE_SAMPLES(AVERAGE_SAMPLES)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_switches     (req_switches),
      .req_adc_sample   (req_adc_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_segments     (rsp_segments),
      .rsp_digit_enables(rsp_digit_enables),
      .rsp_led_mode_two (rsp_led_mode_two),
      .rsp_led_mode_four(rsp_led_mode_four)
   );

   display_scan_checker #(
      .AVERAGE_SAMPLES(AVERAGE_SAMPLES)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_switches     (req_switches),
      .req_adc_sample   (req_adc_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_segments     (rsp_segments),
      .rsp_digit_enables(rsp_digit_enables),
      .rsp_led_mode_two (rsp_led_mode_two),
      .rsp_led_mode_four(rsp_led_mode_four),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .averages_done    (averages_done)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offers one item and returns at the falling edge after it was taken.
   task automatic send_item(input logic [aass_pkg::SWITCH_W-1:0] sw,
                            input logic [aass_pkg::SAMPLE_W-1:0] smp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_switches   <= sw;
      req_adc_sample <= smp;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Each block of samples is either fully random or one constant level, so that
   // averages land on the digit boundaries as well as anywhere in the range.
   task automatic send_random_items(input int unsigned count);
      logic [aass_pkg::SWITCH_W-1:0] sw;
      logic [aass_pkg::SAMPLE_W-1:0] smp;
      logic [aass_pkg::SAMPLE_W-1:0] level;
      logic                          level_block;
      level       = '0;
      level_block = 1'b0;
      repeat (count) begin
         if (items_sent % AVERAGE_SAMPLES == 0) begin
            level_block = ($urandom_range(0, 99) < 60);
            case ($urandom_range(0, 7))
               0:       level = '0;
               1:       level = SAMPLE_MAX;
               2:       level = 10'd999;
               3:       level = 10'd1000;
               4:       level = 10'd99;
               5:       level = 10'd100;
               6:       level = 10'd9;
               default: level = aass_pkg::SAMPLE_W'($urandom_range(0, 1023));
            endcase
         end
         smp = level_block ? level : aass_pkg::SAMPLE_W'($urandom_range(0, 1023));
         case ($urandom_range(0, 19))
            0, 1, 2:     sw = aass_pkg::SWITCH_W'($urandom_range(0, 7));
            3, 4, 5, 6:  sw = aass_pkg::MODE_TEST;
            7, 8, 9, 10, 11, 12: sw = aass_pkg::MODE_POINT_HUNDREDS;
            default:     sw = aass_pkg::MODE_POINT_THOUSANDS;
         endcase
         send_item(sw, smp);
      end
   endtask

   // Output side: random stalls, or one long hold-off when asked.
   initial begin
      rsp_stall  = 1'b0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_taken = 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("No item moved for %0d cycles.", IDLE_LIMIT);
      $display("[adc_average_sevenseg_scan] ERROR");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_switches   = SW_ALL_OFF;
      req_adc_sample = '0;
      hold_request   = 1'b0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      items_sent     = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: every switch word, full scans of each shown mode before any
      // average exists, and a blank word that resets the scan part way through.
      send_item(aass_pkg::MODE_TEST, '0);
      send_item(aass_pkg::MODE_TEST, SAMPLE_MAX);
      send_item(aass_pkg::MODE_TEST, '0);
      send_item(aass_pkg::MODE_TEST, SAMPLE_MAX);
      send_item(aass_pkg::MODE_TEST, '0);
      send_item(SW_ALL_OFF, SAMPLE_MAX);
      send_item(aass_pkg::MODE_POINT_HUNDREDS, '0);
      send_item(aass_pkg::MODE_POINT_HUNDREDS, SAMPLE_MAX);
      send_item(aass_pkg::MODE_POINT_HUNDREDS, 10'h155);
      send_item(aass_pkg::MODE_POINT_HUNDREDS, 10'h2AA);
      send_item(SW_TEST_HUNDREDS, SAMPLE_MAX);
      send_item(aass_pkg::MODE_POINT_THOUSANDS, '0);
      send_item(aass_pkg::MODE_POINT_THOUSANDS, SAMPLE_MAX);
      send_item(aass_pkg::MODE_POINT_THOUSANDS, '0);
      send_item(aass_pkg::MODE_POINT_THOUSANDS, SAMPLE_MAX);
      send_item(SW_TEST_THOUSANDS, '0);
      send_item(SW_BOTH_POINTS, SAMPLE_MAX);
      send_item(SW_ALL_ON, '0);
      send_item(aass_pkg::MODE_TEST, SAMPLE_MAX);
      send_item(aass_pkg::MODE_TEST, '0);
      send_item(SW_ALL_ON, SAMPLE_MAX);
      send_item(aass_pkg::MODE_TEST, '0);

      send_idle_pct = 16;
      recv_idle_pct = 88;
      send_random_items(PHASE_ITEMS);

      send_idle_pct = 88;
      recv_idle_pct = 16;
      send_random_items(PHASE_ITEMS);

      // Hold the output back while items keep coming until the input stalls.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      send_random_items(PRESSURE_ITEMS);
      send_random_items(PHASE_ITEMS);

      req_valid <= 1'b0;
      while (pending_count != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Sent %0d items across all switch words and %0d completed sample averages,",
               items_sent, averages_done);
      $display("with input gaps, output stalls and one long output hold-off.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("[adc_average_sevenseg_scan] OK");
      end else begin
         $display("[adc_average_sevenseg_scan] ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/aass_pkg.sv
sv/aass_accum.sv
sv/aass_display.sv
sv/adc_average_sevenseg_scan.sv
tb/display_scan_checker.sv
tb/testbench.sv
